// ===== sv/i2c_register_access_sequencer_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_TOP_ASSERT_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever the trigger holds, the check must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (check)) else $error(msg);

`endif

// ===== sv/i2c_ras_pkg.sv =====
package i2c_ras_pkg;

  localparam logic [1:0] CMD_PROBE = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_RESP  = 2'd3;

  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_SEND  = 3'd1;
  localparam logic [2:0] ACT_RACK  = 3'd2;
  localparam logic [2:0] ACT_RNACK = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;
  localparam logic [2:0] ACT_DONE  = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] write_value;
    logic        bus_ok;
    logic [7:0]  bus_data;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  action_byte;
    logic        done_error;
    logic [15:0] read_value;
    logic        last;
  } result_t;

  // Up to two result words produced by one input word.
  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] n;
  } res_pair_t;

  function automatic result_t mk_one(input logic [2:0] act, input logic [7:0] byte_val);
    result_t r;
    r.action      = act;
    r.action_byte = byte_val;
    r.done_error  = 1'b0;
    r.read_value  = 16'd0;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic result_t mk_stop();
    result_t r;
    r        = '0;
    r.action = ACT_STOP;
    return r;
  endfunction

  function automatic result_t mk_done(input logic err, input logic [15:0] val);
    result_t r;
    r.action      = ACT_DONE;
    r.action_byte = 8'd0;
    r.done_error  = err;
    r.read_value  = val;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/i2c_ras_if.sv =====
interface i2c_ras_cmd_if;
  import i2c_ras_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2c_ras_res_if;
  import i2c_ras_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/i2c_register_access_sequencer_top.sv =====
// Channel  Direction  Payload
// req      in         cmd, dev_addr, reg_addr, write_value, bus_ok, bus_data
// rsp      out        action, action_byte, done_error, read_value, last
//
// One word is accepted per cycle while req.ready is high; it is registered,
// decoded against the sequencer state and its results land in a two-word
// output register, from which a stop-and-done pair leaves as two words in
// turn. Synchronous reset returns to idle.
// A stalled output holds its word and backs up into req.ready.
module i2c_register_access_sequencer_top (
  input logic           clk,
  input logic           rst,
  i2c_ras_cmd_if.sink   req,
  i2c_ras_res_if.source rsp
);
  import i2c_ras_pkg::*;

  logic      in_valid;
  cmd_item_t in_item;
  res_pair_t pair;
  logic      free;
  logic      advance;

  assign advance   = in_valid && (pair.n == 2'd0 || free);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item <= req.data;
    end
  end

  i2c_ras_core u_core (
    .clk  (clk),
    .rst  (rst),
    .item (in_item),
    .step (advance),
    .res  (pair)
  );

  i2c_ras_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .load (advance && pair.n != 2'd0),
    .pair (pair),
    .free (free),
    .rsp  (rsp)
  );

endmodule

// ===== sv/i2c_ras_core.sv =====
module i2c_ras_core (
  input  logic                    clk,
  input  logic                    rst,
  input  i2c_ras_pkg::cmd_item_t  item,
  input  logic                    step,
  output i2c_ras_pkg::res_pair_t  res
);
  import i2c_ras_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_ADDR, PH_REG, PH_DHI,
    PH_DLO, PH_RSTART, PH_RADDR, PH_RHI, PH_RLO
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  op_kind;
  logic [6:0]  saved_device;
  logic [7:0]  saved_register;
  logic [15:0] saved_value;
  logic [7:0]  high_byte;
  logic [7:0]  wr_addr;

  assign wr_addr = {saved_device, 1'b0};

  always_comb begin
    phase_next = phase;
    res        = '0;
    if (item.cmd != CMD_RESP) begin
      if (phase == PH_IDLE) begin
        res.r0     = mk_one(ACT_START, 8'd0);
        res.n      = 2'd1;
        phase_next = PH_START;
      end
    end else begin
      // Every finish is a stop word followed by a done word, back to idle.
      case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_RHI: begin
          res.r0     = mk_one(ACT_RNACK, 8'd0);
          res.n      = 2'd1;
          phase_next = PH_RLO;
        end
        PH_RLO: begin
          res.r0     = mk_stop();
          res.r1     = mk_done(1'b0, {high_byte, item.bus_data});
          res.n      = 2'd2;
          phase_next = PH_IDLE;
        end
        default: begin
          if (!item.bus_ok) begin
            res.r0     = mk_stop();
            res.r1     = mk_done(1'b1, 16'd0);
            res.n      = 2'd2;
            phase_next = PH_IDLE;
          end else begin
            res.n = 2'd1;
            case (phase)
              PH_START: begin
                res.r0     = mk_one(ACT_SEND, wr_addr);
                phase_next = PH_ADDR;
              end
              PH_ADDR: begin
                if (op_kind == CMD_PROBE) begin
                  res.r0     = mk_stop();
                  res.r1     = mk_done(1'b0, 16'd0);
                  res.n      = 2'd2;
                  phase_next = PH_IDLE;
                end else begin
                  res.r0     = mk_one(ACT_SEND, saved_register);
                  phase_next = PH_REG;
                end
              end
              PH_REG: begin
                if (op_kind == CMD_READ) begin
                  res.r0     = mk_one(ACT_START, 8'd0);
                  phase_next = PH_RSTART;
                end else begin
                  res.r0     = mk_one(ACT_SEND, saved_value[15:8]);
                  phase_next = PH_DHI;
                end
              end
              PH_DHI: begin
                res.r0     = mk_one(ACT_SEND, saved_value[7:0]);
                phase_next = PH_DLO;
              end
              PH_DLO: begin
                res.r0     = mk_stop();
                res.r1     = mk_done(1'b0, 16'd0);
                res.n      = 2'd2;
                phase_next = PH_IDLE;
              end
              PH_RSTART: begin
                res.r0     = mk_one(ACT_SEND, wr_addr | 8'd1);
                phase_next = PH_RADDR;
              end
              PH_RADDR: begin
                res.r0     = mk_one(ACT_RACK, 8'd0);
                phase_next = PH_RHI;
              end
              default: begin
                res.n      = 2'd0;
                phase_next = PH_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      op_kind        <= CMD_PROBE;
      saved_device   <= '0;
      saved_register <= '0;
      saved_value    <= '0;
      high_byte      <= '0;
    end else if (step) begin
      phase <= phase_next;
      if (item.cmd != CMD_RESP && phase == PH_IDLE) begin
        op_kind        <= item.cmd;
        saved_device   <= item.dev_addr;
        saved_register <= item.reg_addr;
        saved_value    <= item.write_value;
      end
      if (item.cmd == CMD_RESP && phase == PH_RHI) begin
        high_byte <= item.bus_data;
      end
    end
  end

endmodule

// ===== sv/i2c_ras_outq.sv =====
module i2c_ras_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  i2c_ras_pkg::res_pair_t pair,
  output logic                   free,
  i2c_ras_res_if.source          rsp
);
  import i2c_ras_pkg::*;

  result_t    slot0;
  result_t    slot1;
  logic [1:0] cnt;
  logic       take;

  assign take      = rsp.valid && rsp.ready;
  assign rsp.valid = (cnt != 2'd0);
  assign rsp.data  = slot0;
  // A new pair may enter when the queue is empty, or once the word in front is the last one and is leaving.
  assign free      = (cnt == 2'd0) || (cnt == 2'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt   <= pair.n;
      slot0 <= pair.r0;
      slot1 <= pair.r1;
    end else if (take) begin
      cnt   <= cnt - 2'd1;
      slot0 <= slot1;
    end
  end

endmodule

// ===== sv/i2c_ras_checker.sv =====
`include "i2c_register_access_sequencer_top_assert.svh"

module i2c_ras_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input i2c_ras_pkg::result_t rsp_data
);
  import i2c_ras_pkg::*;

  `ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "output word changed while stalled")
  `ASSERT_ALWAYS(a_err_on_done, clk, rst, !(rsp_valid && rsp_data.done_error) || (rsp_data.action == ACT_DONE && rsp_data.read_value == 16'd0), "error flag outside a failed done")
  `ASSERT_ALWAYS(a_stop_not_last, clk, rst, !(rsp_valid && rsp_data.action == ACT_STOP) || !rsp_data.last, "stop word marked last")
  `ASSERT_NEXT(a_done_after_stop, clk, rst, rsp_valid && rsp_ready && rsp_data.action == ACT_STOP, rsp_valid && rsp_data.action == ACT_DONE, "stop not followed by done")
  `ASSERT_ALWAYS(a_byte_on_send, clk, rst, !rsp_valid || rsp_data.action == ACT_SEND || rsp_data.action_byte == 8'd0, "byte on a non-send word")

endmodule

bind i2c_register_access_sequencer_top i2c_ras_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
